/* rtl/core/jts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, codes and byte tables of the JSON token serializer.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int MAX_DEPTH = 32;
    localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // token commands
    localparam logic [3:0] CMD_STR_OPEN  = 4'd0;
    localparam logic [3:0] CMD_STR_BYTE  = 4'd1;
    localparam logic [3:0] CMD_STR_CLOSE = 4'd2;
    localparam logic [3:0] CMD_OPEN_ARR  = 4'd3;
    localparam logic [3:0] CMD_OPEN_OBJ  = 4'd4;
    localparam logic [3:0] CMD_CLOSE     = 4'd5;
    localparam logic [3:0] CMD_NULL      = 4'd6;
    localparam logic [3:0] CMD_TRUE      = 4'd7;
    localparam logic [3:0] CMD_FALSE     = 4'd8;
    localparam logic [3:0] CMD_NUM_START = 4'd9;
    localparam logic [3:0] CMD_RAW_BYTE  = 4'd10;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_CONT   = 3'd1;
    localparam logic [2:0] ERR_EMPTY     = 3'd2;
    localparam logic [2:0] ERR_KEY_ONLY  = 3'd3;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

    // body kinds of a queued job
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_CHAR  = 3'd1;
    localparam logic [2:0] KIND_ESC   = 3'd2;
    localparam logic [2:0] KIND_NULL  = 3'd3;
    localparam logic [2:0] KIND_TRUE  = 3'd4;
    localparam logic [2:0] KIND_FALSE = 3'd5;

    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    typedef struct packed {
        logic odd;
        logic has;
        logic obj;
    } nest_t;

    typedef struct packed {
        logic       sep_vld;
        logic [7:0] sep_chr;
        logic [2:0] kind;
        logic [7:0] chr;
        logic [2:0] err;
    } job_t;

    // short escape letter, zero when the byte has none
    function automatic logic [7:0] esc_code(input logic [7:0] c);
        logic [7:0] r;
        begin
            case (c)
                CH_QUOTE:  r = CH_QUOTE;
                CH_BSLASH: r = CH_BSLASH;
                8'h0A:     r = 8'h6E;
                8'h0D:     r = 8'h72;
                8'h08:     r = 8'h62;
                8'h0C:     r = 8'h66;
                8'h09:     r = 8'h74;
                default:   r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic needs_uesc(input logic [7:0] c);
        return (c < 8'h20) || c[7];
    endfunction

    function automatic logic [7:0] hex_chr(input logic [3:0] n);
        logic [7:0] r;
        begin
            if (n < 4'd10)
                r = 8'h30 + {4'd0, n};
            else
                r = 8'h37 + {4'd0, n};
            return r;
        end
    endfunction

    function automatic logic [2:0] body_len(input logic [2:0] kind, input logic [7:0] c);
        logic [2:0] r;
        begin
            case (kind)
                KIND_CHAR:  r = 3'd1;
                KIND_ESC:
                begin
                    if (esc_code(c) != 8'h00)
                        r = 3'd2;
                    else if (needs_uesc(c))
                        r = 3'd6;
                    else
                        r = 3'd1;
                end
                KIND_NULL:  r = 3'd4;
                KIND_TRUE:  r = 3'd4;
                KIND_FALSE: r = 3'd5;
                default:    r = 3'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] body_byte(input logic [2:0] kind, input logic [7:0] c,
                                             input logic [2:0] q);
        logic [7:0]  r;
        logic [7:0]  ec;
        logic [31:0] w4;
        logic [39:0] w5;
        begin
            ec = esc_code(c);
            r  = c;
            w4 = 32'h0;
            w5 = "false";
            case (kind)
                KIND_ESC:
                begin
                    if (ec != 8'h00)
                        r = (q == 3'd0) ? CH_BSLASH : ec;
                    else if (needs_uesc(c))
                    begin
                        case (q)
                            3'd0:    r = CH_BSLASH;
                            3'd1:    r = CH_U;
                            3'd2:    r = CH_ZERO;
                            3'd3:    r = CH_ZERO;
                            3'd4:    r = hex_chr(c[7:4]);
                            default: r = hex_chr(c[3:0]);
                        endcase
                    end
                end
                KIND_NULL, KIND_TRUE:
                begin
                    w4 = (kind == KIND_NULL) ? "null" : "true";
                    case (q)
                        3'd0:    r = w4[31:24];
                        3'd1:    r = w4[23:16];
                        3'd2:    r = w4[15:8];
                        default: r = w4[7:0];
                    endcase
                end
                KIND_FALSE:
                begin
                    case (q)
                        3'd0:    r = w5[39:32];
                        3'd1:    r = w5[31:24];
                        3'd2:    r = w5[23:16];
                        3'd3:    r = w5[15:8];
                        default: r = w5[7:0];
                    endcase
                end
                default: r = c;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/json_token_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_serializer
// Turns a stream of JSON tokens into JSON text bytes with string escaping.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_*     | in  | tuser: command[3:0]; tdata: data_byte[7:0]
//  m_*     | out | tdata: out_byte[7:0]; tuser: byte_valid[0], error[3:1]; tlast: last
//
//  A token is taken every cycle while the 4-entry job queue has room; the
//  classifier and container stack update in that same cycle.
//  The byte expander gives one result per cycle unless the output stalls, 1 to 6
//  per token (a separator plus up to five word bytes, or a six-byte \u00XX escape).
//  Reset clears the stack depth, the queue and the output register.
//  A stalled output holds its result; the queue absorbs the gap upstream.
// ----------------------------------------------------------------------------
module json_token_serializer
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic [3:0] s_tuser,   // command[3:0]
    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata,   // out_byte[7:0]
    output      logic [3:0] m_tuser,   // byte_valid[0], error[3:1]
    output      logic       m_tlast
);
    import jts_pkg::*;

    logic               acc;
    logic               q_full;
    logic               q_vld;
    logic               q_pop;
    job_t               f_job;
    job_t               q_job;
    logic [DEPTH_W-1:0] depth;

    assign s_tready = !q_full;
    assign acc      = s_tvalid && s_tready;

    jts_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .acc   (acc),
        .cmd   (s_tuser),
        .dat   (s_tdata),
        .job   (f_job),
        .depth (depth)
    );

    jts_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (acc),
        .push_job (f_job),
        .pop      (q_pop),
        .full     (q_full),
        .vld      (q_vld),
        .head     (q_job)
    );

    jts_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_vld    (q_vld),
        .q_job    (q_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(acc) |-> $stable(depth))
        else $error("nesting depth moved without a token");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("result without byte is not last");

    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:1] != ERR_NONE |-> !m_tuser[0] && m_tdata == 8'h00)
        else $error("error result carries a byte");

endmodule
`default_nettype wire

/* rtl/core/jts_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_front
// Token classifier: keeps the container stack, checks each token and turns
// it into a job (separator, body kind, byte, error) for the byte expander.
// ----------------------------------------------------------------------------
module jts_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        acc,
    input  wire logic [3:0]                  cmd,
    input  wire logic [7:0]                  dat,
    output      jts_pkg::job_t               job,
    output      logic [jts_pkg::DEPTH_W-1:0] depth
);
    import jts_pkg::*;

    nest_t                stack [MAX_DEPTH];
    logic [DEPTH_W-1:0]   depth_reg;
    logic [DEPTH_W-1:0]   depth_next;
    logic [DEPTH_W-1:0]   depth_m1;
    logic [IDX_W-1:0]     top_idx;
    logic [IDX_W-1:0]     push_idx;
    nest_t                top;
    nest_t                top_upd;
    nest_t                push_ent;
    logic                 have;
    logic                 stack_full;
    logic                 upd_top;
    logic                 push;

    always_comb
    begin
        depth_m1   = depth_reg - DEPTH_W'(1);
        top_idx    = depth_m1[IDX_W-1:0];
        push_idx   = depth_reg[IDX_W-1:0];
        top        = stack[top_idx];
        have       = (depth_reg != '0);
        stack_full = (depth_reg >= DEPTH_W'(MAX_DEPTH));
        top_upd    = '{odd: ~top.odd, has: 1'b1, obj: top.obj};
        push_ent   = '{odd: 1'b0, has: 1'b0, obj: (cmd == CMD_OPEN_OBJ)};

        job.sep_vld = 1'b0;
        job.sep_chr = (top.obj && top.odd) ? CH_COLON : CH_COMMA;
        job.kind    = KIND_NONE;
        job.chr     = dat;
        job.err     = ERR_NONE;
        upd_top     = 1'b0;
        push        = 1'b0;
        depth_next  = depth_reg;

        case (cmd)
            CMD_STR_OPEN, CMD_NUM_START:
            begin
                if (!have)
                    job.err = ERR_NO_CONT;
                else
                begin
                    job.sep_vld = top.has;
                    upd_top     = 1'b1;
                    if (cmd == CMD_STR_OPEN)
                    begin
                        job.kind = KIND_CHAR;
                        job.chr  = CH_QUOTE;
                    end
                end
            end
            CMD_STR_BYTE:
                job.kind = KIND_ESC;
            CMD_STR_CLOSE:
            begin
                job.kind = KIND_CHAR;
                job.chr  = CH_QUOTE;
            end
            CMD_OPEN_ARR, CMD_OPEN_OBJ:
            begin
                if (stack_full)
                    job.err = ERR_OVERFLOW;
                else
                begin
                    job.sep_vld = have && top.has;
                    upd_top     = have;
                    push        = 1'b1;
                    depth_next  = depth_reg + DEPTH_W'(1);
                    job.kind    = KIND_CHAR;
                    job.chr     = (cmd == CMD_OPEN_OBJ) ? CH_LBRACE : CH_LBRACK;
                end
            end
            CMD_CLOSE:
            begin
                if (!have)
                    job.err = ERR_EMPTY;
                else if (top.obj && top.odd)
                    job.err = ERR_KEY_ONLY;
                else
                begin
                    job.kind   = KIND_CHAR;
                    job.chr    = top.obj ? CH_RBRACE : CH_RBRACK;
                    depth_next = depth_m1;
                end
            end
            CMD_NULL, CMD_TRUE, CMD_FALSE:
            begin
                job.sep_vld = have && top.has;
                upd_top     = have;
                if (cmd == CMD_NULL)
                    job.kind = KIND_NULL;
                else if (cmd == CMD_TRUE)
                    job.kind = KIND_TRUE;
                else
                    job.kind = KIND_FALSE;
            end
            CMD_RAW_BYTE:
                job.kind = KIND_CHAR;
            default:
                job.kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            depth_reg <= '0;
        else if (acc)
            depth_reg <= depth_next;
    end

    // stack entries are written on push before they are ever read
    always_ff @(posedge clk)
    begin
        if (acc && upd_top)
            stack[top_idx] <= top_upd;
        if (acc && push)
            stack[push_idx] <= push_ent;
    end

    assign depth = depth_reg;

endmodule
`default_nettype wire

/* rtl/core/jts_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_fifo
// Short job queue between the token classifier and the byte expander.
// ----------------------------------------------------------------------------
module jts_fifo
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jts_pkg::job_t push_job,
    input  wire logic          pop,
    output      logic          full,
    output      logic          vld,
    output      jts_pkg::job_t head
);
    import jts_pkg::*;

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        full     = (cnt_reg == QCNT_W'(QDEPTH));
        vld      = (cnt_reg != '0);
        head     = mem[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && vld;
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule
`default_nettype wire

/* rtl/core/jts_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_back
// Byte expander: walks the separator and body bytes of the head job, one
// byte per cycle while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module jts_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_vld,
    input  wire jts_pkg::job_t q_job,
    output      logic          q_pop,
    output      logic          m_tvalid,
    input  wire logic          m_tready,
    output      logic [7:0]    m_tdata,
    output      logic [3:0]    m_tuser,
    output      logic          m_tlast
);
    import jts_pkg::*;

    logic [2:0] pos_reg;
    logic [2:0] total;
    logic [2:0] q_off;
    logic       load;
    logic       take;
    logic       no_bytes;
    logic       is_last;
    logic [7:0] byte_now;
    logic       m_tvalid_reg;
    logic [7:0] byte_reg;
    logic       bvld_reg;
    logic       last_reg;
    logic [2:0] err_reg;

    always_comb
    begin
        total    = {2'b00, q_job.sep_vld} + body_len(q_job.kind, q_job.chr);
        no_bytes = (total == 3'd0);
        is_last  = no_bytes || (pos_reg == total - 3'd1);
        q_off    = pos_reg - {2'b00, q_job.sep_vld};
        if (q_job.sep_vld && pos_reg == 3'd0)
            byte_now = q_job.sep_chr;
        else
            byte_now = body_byte(q_job.kind, q_job.chr, q_off);
        load  = !m_tvalid_reg || m_tready;
        take  = load && q_vld;
        q_pop = take && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            if (load)
                m_tvalid_reg <= q_vld;
            if (take)
                pos_reg <= is_last ? 3'd0 : pos_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= no_bytes ? 8'h00 : byte_now;
            bvld_reg <= !no_bytes;
            last_reg <= is_last;
            err_reg  <= no_bytes ? q_job.err : ERR_NONE;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {err_reg, bvld_reg};
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

/* tb/jts_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jts_text_checker
// Watches both streams of the JSON token serializer, keeps its own container
// stack, works out the text bytes of every accepted token and compares each
// accepted output item against them field by field.
// ----------------------------------------------------------------------------
module jts_text_checker
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,   // data_byte[7:0]
    input  wire logic [3:0] s_tuser,   // command[3:0]
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,   // out_byte[7:0]
    input  wire logic [3:0] m_tuser,   // byte_valid[0], error[3:1]
    input  wire logic       m_tlast,
    output      int         fail_count,
    output      int         pending
);
    import jts_pkg::*;

    typedef struct packed {
        logic [7:0] text;
        logic       valid;
        logic       last;
        logic [2:0] err;
    } text_item_t;

    nest_t      nest_mem [MAX_DEPTH];
    int         nest_lvl;
    logic [7:0] tok_bytes [$];
    text_item_t text_q [$];
    text_item_t want;
    int         errs = 0;

    task automatic report_mismatch(input string msg);
        errs++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got 0x%02h, want 0x%02h", name, got, exp_val));
    endtask

    // comma in arrays; in objects a colon after a key, a comma after a value
    function automatic void add_separator();
        nest_t e;
        if (nest_lvl == 0)
            return;
        e = nest_mem[nest_lvl - 1];
        if (e.has)
            tok_bytes.push_back((e.obj && e.odd) ? CH_COLON : CH_COMMA);
        e.has = 1'b1;
        e.odd = ~e.odd;
        nest_mem[nest_lvl - 1] = e;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] v);
        return (v > 4'd9) ? (8'h37 + {4'd0, v}) : (CH_ZERO + {4'd0, v});
    endfunction

    function automatic void add_escaped(input logic [7:0] c);
        logic [7:0] letter;
        case (c)
            CH_QUOTE:  letter = CH_QUOTE;
            CH_BSLASH: letter = CH_BSLASH;
            8'h0A:     letter = "n";
            8'h0D:     letter = "r";
            8'h08:     letter = "b";
            8'h0C:     letter = "f";
            8'h09:     letter = "t";
            default:   letter = 8'h00;
        endcase
        if (letter != 8'h00)
        begin
            tok_bytes.push_back(CH_BSLASH);
            tok_bytes.push_back(letter);
        end
        else if (c < 8'h20 || c >= 8'h80)
        begin
            tok_bytes.push_back(CH_BSLASH);
            tok_bytes.push_back(CH_U);
            tok_bytes.push_back(CH_ZERO);
            tok_bytes.push_back(CH_ZERO);
            tok_bytes.push_back(hex_upper(c[7:4]));
            tok_bytes.push_back(hex_upper(c[3:0]));
        end
        else
            tok_bytes.push_back(c);
    endfunction

    function automatic void add_word(input logic [39:0] w, input int n);
        for (int i = n - 1; i >= 0; i--)
            tok_bytes.push_back(w[i*8 +: 8]);
    endfunction

    task automatic predict_token(input logic [3:0] cmd, input logic [7:0] data);
        logic [2:0] fault;
        nest_t      top;
        text_item_t r;
        fault = ERR_NONE;
        tok_bytes.delete();
        case (cmd)
            CMD_STR_OPEN:
                if (nest_lvl == 0)
                    fault = ERR_NO_CONT;
                else
                begin
                    add_separator();
                    tok_bytes.push_back(CH_QUOTE);
                end
            CMD_STR_BYTE:  add_escaped(data);
            CMD_STR_CLOSE: tok_bytes.push_back(CH_QUOTE);
            CMD_OPEN_ARR, CMD_OPEN_OBJ:
                if (nest_lvl >= MAX_DEPTH)
                    fault = ERR_OVERFLOW;
                else
                begin
                    add_separator();
                    top.obj = (cmd == CMD_OPEN_OBJ);
                    top.has = 1'b0;
                    top.odd = 1'b0;
                    nest_mem[nest_lvl] = top;
                    nest_lvl++;
                    tok_bytes.push_back(top.obj ? CH_LBRACE : CH_LBRACK);
                end
            CMD_CLOSE:
                if (nest_lvl == 0)
                    fault = ERR_EMPTY;
                else
                begin
                    top = nest_mem[nest_lvl - 1];
                    if (top.obj && top.odd)
                        fault = ERR_KEY_ONLY;
                    else
                    begin
                        tok_bytes.push_back(top.obj ? CH_RBRACE : CH_RBRACK);
                        nest_lvl--;
                    end
                end
            CMD_NULL:
            begin
                add_separator();
                add_word("null", 4);
            end
            CMD_TRUE:
            begin
                add_separator();
                add_word("true", 4);
            end
            CMD_FALSE:
            begin
                add_separator();
                add_word("false", 5);
            end
            CMD_NUM_START:
                if (nest_lvl == 0)
                    fault = ERR_NO_CONT;
                else
                    add_separator();
            CMD_RAW_BYTE: tok_bytes.push_back(data);
            default: ;
        endcase

        // errors and byte-less tokens give one empty item
        if (fault != ERR_NONE || tok_bytes.size() == 0)
        begin
            r.text  = 8'h00;
            r.valid = 1'b0;
            r.last  = 1'b1;
            r.err   = fault;
            text_q.push_back(r);
        end
        else
        begin
            foreach (tok_bytes[i])
            begin
                r.text  = tok_bytes[i];
                r.valid = 1'b1;
                r.last  = (i == tok_bytes.size() - 1);
                r.err   = ERR_NONE;
                text_q.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nest_lvl = 0;
            text_q.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_token(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (text_q.size() == 0)
                    report_mismatch($sformatf("item 0x%02h with nothing pending", m_tdata));
                else
                begin
                    want = text_q.pop_front();
                    check_field("out_byte", m_tdata, want.text);
                    check_field("byte_valid", {7'd0, m_tuser[0]}, {7'd0, want.valid});
                    check_field("error", {5'd0, m_tuser[3:1]}, {5'd0, want.err});
                    check_field("last", {7'd0, m_tlast}, {7'd0, want.last});
                end
            end
            pending <= text_q.size();
        end
        fail_count <= errs;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives JSON token streams into the serializer: a directed opening, a full
// nesting dive and mostly well-formed random documents with some noise, with
// random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_top;
    import jts_pkg::*;

    localparam int         N_RANDOM     = 140;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 20;
    localparam logic [3:0] CMD_UNUSED   = 4'd15;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic [3:0] s_tuser  = CMD_NULL;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire [7:0]  m_tdata;
    wire [3:0]  m_tuser;
    wire        m_tlast;
    int         fail_count;
    int         pending;

    int         cycle_cnt      = 0;
    int         sink_stall_pct = 0;
    int         sink_hold      = 0;
    int         src_gap_pct    = 0;
    int         sent_items     = 0;

    // container shadow used to shape the stimulus
    int                   lvl = 0;
    bit [MAX_DEPTH-1:0]   lvl_obj;
    bit [MAX_DEPTH-1:0]   lvl_odd;

    int         base;
    int         r;
    int         r2;
    int         close_pct;
    int         str_left = 0;
    int         num_left = 0;
    bit         in_str   = 1'b0;
    bit         dived    = 1'b0;
    logic [3:0] cmd_pick;
    logic [7:0] tricky [0:11] = '{8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h08, 8'h0C,
                                  8'h09, 8'h00, 8'h1F, 8'h20, 8'h7F, 8'h80};

    json_token_serializer i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    jts_text_checker i_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // output stalls: mostly short, a few long, with quiet stretches
    always @(posedge clk)
    begin
        if (cycle_cnt % 300 == 0)
        begin
            case ($urandom_range(0, 2))
                0:       sink_stall_pct <= 0;
                1:       sink_stall_pct <= 15;
                default: sink_stall_pct <= 50;
            endcase
        end
        if (sink_hold > 0)
        begin
            m_tready  <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < sink_stall_pct)
                sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    task automatic send(input logic [3:0] cmd, input logic [7:0] data);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        case (cmd)
            CMD_STR_OPEN, CMD_NUM_START, CMD_NULL, CMD_TRUE, CMD_FALSE:
                if (lvl > 0)
                    lvl_odd[lvl - 1] = ~lvl_odd[lvl - 1];
            CMD_OPEN_ARR, CMD_OPEN_OBJ:
                if (lvl < MAX_DEPTH)
                begin
                    if (lvl > 0)
                        lvl_odd[lvl - 1] = ~lvl_odd[lvl - 1];
                    lvl_obj[lvl] = (cmd == CMD_OPEN_OBJ);
                    lvl_odd[lvl] = 1'b0;
                    lvl++;
                end
            CMD_CLOSE:
                if (lvl > 0 && !(lvl_obj[lvl - 1] && lvl_odd[lvl - 1]))
                    lvl--;
            default: ;
        endcase

        if (cmd <= CMD_RAW_BYTE)
        begin
            sent_items++;
            if (sent_items % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 20;
                    default: src_gap_pct = 60;
                endcase
            end
        end

        gap = 0;
        if ($urandom_range(0, 99) < src_gap_pct)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic open_any();
        send($urandom_range(0, 1) ? CMD_OPEN_OBJ : CMD_OPEN_ARR, 8'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // top-level errors, literals and pass-through items
        send(CMD_NUM_START, 8'h00);
        send(CMD_STR_OPEN, 8'hFF);
        send(CMD_CLOSE, 8'h00);
        send(CMD_NULL, 8'h00);
        send(CMD_TRUE, 8'h00);
        send(CMD_FALSE, 8'h00);
        send(CMD_UNUSED, 8'hA5);
        send(CMD_RAW_BYTE, 8'h00);
        send(CMD_STR_BYTE, 8'hFF);
        // object with a key left open, then key/value pairs
        send(CMD_OPEN_OBJ, 8'h00);
        send(CMD_STR_OPEN, 8'h00);
        send(CMD_STR_BYTE, 8'h22);
        send(CMD_STR_BYTE, 8'h5C);
        send(CMD_STR_BYTE, 8'h7F);
        send(CMD_STR_CLOSE, 8'h00);
        send(CMD_CLOSE, 8'h00);
        send(CMD_NUM_START, 8'h00);
        send(CMD_RAW_BYTE, CH_ZERO + 8'd7);
        send(CMD_STR_OPEN, 8'h00);
        send(CMD_STR_BYTE, 8'h0A);
        send(CMD_STR_CLOSE, 8'h00);
        send(CMD_OPEN_ARR, 8'h00);
        send(CMD_NUM_START, 8'h00);
        send(CMD_RAW_BYTE, 8'h31);
        send(CMD_FALSE, 8'h00);
        send(CMD_CLOSE, 8'h00);
        send(CMD_CLOSE, 8'h00);

        base = sent_items;
        while (sent_items - base < N_RANDOM)
        begin
            r = $urandom_range(0, 99);
            if (str_left > 0)
            begin
                str_left--;
                send(CMD_STR_BYTE, (r < 50) ? tricky[$urandom_range(0, 11)] : 8'($urandom));
            end
            else if (in_str)
            begin
                in_str = 1'b0;
                send(CMD_STR_CLOSE, 8'($urandom));
            end
            else if (num_left > 0)
            begin
                num_left--;
                send(CMD_RAW_BYTE, (r < 80) ? CH_ZERO + 8'($urandom_range(0, 9)) : 8'($urandom));
            end
            else if (r < 8)
            begin
                cmd_pick = 4'($urandom_range(0, 15));
                send(cmd_pick, 8'($urandom));
            end
            else if (!dived && sent_items - base >= 60)
            begin
                // fill the stack, then push once more to overflow it
                dived = 1'b1;
                while (lvl < MAX_DEPTH)
                    open_any();
                open_any();
            end
            else if (lvl == 0)
            begin
                if (r < 20)
                    send(CMD_NULL + 4'($urandom_range(0, 2)), 8'($urandom));
                else
                    open_any();
            end
            else
            begin
                close_pct = (lvl * 4 + 8 > 85) ? 85 : lvl * 4 + 8;
                r2 = $urandom_range(0, 99);
                if (r2 < close_pct && !(lvl_obj[lvl - 1] && lvl_odd[lvl - 1]))
                    send(CMD_CLOSE, 8'($urandom));
                else if (r2 >= 85)
                    open_any();
                else if (r < 50)
                begin
                    send(CMD_STR_OPEN, 8'($urandom));
                    in_str   = 1'b1;
                    str_left = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12)
                                                           : $urandom_range(0, 3);
                end
                else if (r < 70)
                begin
                    send(CMD_NUM_START, 8'($urandom));
                    num_left = $urandom_range(1, 4);
                end
                else
                    send(CMD_NULL + 4'($urandom_range(0, 2)), 8'($urandom));
            end
        end

        // close whatever is still open
        if (in_str)
            send(CMD_STR_CLOSE, 8'h00);
        while (lvl > 0)
        begin
            if (lvl_obj[lvl - 1] && lvl_odd[lvl - 1])
                send(CMD_NULL, 8'h00);
            send(CMD_CLOSE, 8'h00);
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
